### hw/rtl/ppp_pkg.sv
// shared types, widths and helpers for the pinhole point projection pipeline
package ppp_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 8;
    localparam int ROT_W     = 20;
    localparam int ROT_ROW_W = 3 * ROT_W;
    localparam int CAM_XY_W  = 64;
    localparam int CAM_Z_W   = 32;
    localparam int FOCAL_W   = 24;
    localparam int PP_W      = 24;
    localparam int SIZE_W    = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 64;

    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = ROT_W + DIFF_W;
    localparam int CAM_W   = PROD_W + 2;
    localparam int MAG_W   = CAM_W;
    localparam int SPLIT_W = (MAG_W + 1) / 2;
    localparam int PLO_W   = SPLIT_W + FOCAL_W;
    localparam int PHI_W   = MAG_W - SPLIT_W + FOCAL_W;
    localparam int NUM_W   = MAG_W + FOCAL_W + 2;
    localparam int DEN_W   = MAG_W + 1;
    localparam int Q_W     = COORD_W + 1;
    localparam int REM_W   = DEN_W + 1;
    localparam int ACC_W   = REM_W + Q_W;
    localparam int RES_W   = Q_W + 2;
    localparam int LIM_W   = COORD_W + 1;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_ROW0        = 4'd0,
        REG_ROT_ROW1        = 4'd1,
        REG_ROT_ROW2        = 4'd2,
        REG_CAM_POS_XY      = 4'd3,
        REG_CAM_POS_Z       = 4'd4,
        REG_FOCAL_PX        = 4'd5,
        REG_PRINCIPAL_POINT = 4'd6,
        REG_IMAGE_SIZE      = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] col_pos;
        logic signed [COORD_W-1:0] row_pos;
        logic                      in_frame;
        logic                      depth_zero;
    } pixel_t;

    typedef struct packed {
        logic [2:0][ROT_ROW_W-1:0] rot_row;
        logic [CAM_XY_W-1:0]       cam_pos_xy;
        logic [CAM_Z_W-1:0]        cam_pos_z;
        logic [FOCAL_W-1:0]        focal_px;
        logic [2*PP_W-1:0]         principal_point;
        logic [2*SIZE_W-1:0]       image_size;
    } cfg_t;

    typedef logic signed [CAM_W-1:0] cam_t;

    typedef struct packed {
        logic valid;
        logic zero;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } ppp_tag_t;

    typedef struct packed {
        logic [ACC_W-1:0] acc_x;
        logic [ACC_W-1:0] acc_y;
        logic [DEN_W-1:0] den;
    } div_data_t;

    function automatic logic signed [ROT_W-1:0] rot_entry(logic [ROT_ROW_W-1:0] row, int j);
        return $signed(row[ROT_ROW_W-1-ROT_W*j -: ROT_W]);
    endfunction

endpackage

### hw/rtl/ppp_transform.sv
// camera offset, rotation products and dot-product sums (three stages)
module ppp_transform
    import ppp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  point_t in_data,
    input  cfg_t   cfg,
    output logic   out_valid,
    output cam_t   out_cam [3]
);

    logic [2:0] vld_reg;
    logic signed [DIFF_W-1:0] diff_reg [3];
    logic signed [DIFF_W-1:0] diff_next [3];
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    cam_t sum_reg [3];
    cam_t sum_next [3];

    always_comb begin
        diff_next[0] = DIFF_W'(in_data.point_x) - DIFF_W'($signed(cfg.cam_pos_xy[31:0]));
        diff_next[1] = DIFF_W'(in_data.point_y) - DIFF_W'($signed(cfg.cam_pos_xy[63:32]));
        diff_next[2] = DIFF_W'(in_data.point_z) - DIFF_W'($signed(cfg.cam_pos_z));
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i][j] = PROD_W'(rot_entry(cfg.rot_row[i], j)) * PROD_W'(diff_reg[j]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum_next[i] = CAM_W'(prod_reg[i][0]) + CAM_W'(prod_reg[i][1])
                        + CAM_W'(prod_reg[i][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg <= diff_next;
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_cam   = sum_reg;

endmodule

### hw/rtl/ppp_scale.sv
// magnitudes, focal scaling and divider setup (four stages)
module ppp_scale
    import ppp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  cam_t      in_cam [3],
    input  cfg_t      cfg,
    output ppp_tag_t  out_tag,
    output div_data_t out_data
);

    ppp_tag_t tag_a_reg, tag_a_next, tag_b_reg, tag_c_reg, tag_d_reg, tag_d_next;
    logic [MAG_W-1:0] mag_reg [3];
    logic [MAG_W-1:0] mag_next [3];
    logic [PLO_W-1:0] plo_reg [2];
    logic [PLO_W-1:0] plo_next [2];
    logic [PHI_W-1:0] phi_reg [2];
    logic [PHI_W-1:0] phi_next [2];
    logic [MAG_W-1:0] magz_reg;
    logic [NUM_W-1:0] num_reg [2];
    logic [NUM_W-1:0] num_next [2];
    logic [DEN_W-1:0] den_reg, den_next;
    div_data_t        data_reg, data_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_next[i] = in_cam[i][CAM_W-1] ? MAG_W'(-in_cam[i]) : MAG_W'(in_cam[i]);
        end
        tag_a_next       = '0;
        tag_a_next.valid = in_valid;
        tag_a_next.zero  = (in_cam[2] == '0);
        tag_a_next.neg_x = in_cam[0][CAM_W-1] ^ in_cam[2][CAM_W-1];
        tag_a_next.neg_y = in_cam[1][CAM_W-1] ^ in_cam[2][CAM_W-1];
    end

    // split multiply by focal length
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            plo_next[l] = PLO_W'(mag_reg[l][SPLIT_W-1:0]) * PLO_W'(cfg.focal_px);
            phi_next[l] = PHI_W'(mag_reg[l][MAG_W-1:SPLIT_W]) * PHI_W'(cfg.focal_px);
        end
    end

    // numerator 2*f*|v| + |z|, denominator 2*|z|
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            num_next[l] = (NUM_W'(phi_reg[l]) << (SPLIT_W + 1)) + (NUM_W'(plo_reg[l]) << 1)
                        + NUM_W'(magz_reg);
        end
        den_next = DEN_W'(magz_reg) << 1;
    end

    always_comb begin
        tag_d_next       = tag_c_reg;
        tag_d_next.ovf_x = (num_reg[0] >> Q_W) >= NUM_W'(den_reg);
        tag_d_next.ovf_y = (num_reg[1] >> Q_W) >= NUM_W'(den_reg);
        data_next.acc_x  = {REM_W'(num_reg[0] >> Q_W), num_reg[0][Q_W-1:0]};
        data_next.acc_y  = {REM_W'(num_reg[1] >> Q_W), num_reg[1][Q_W-1:0]};
        data_next.den    = den_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
        end else if (en) begin
            tag_a_reg <= tag_a_next;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
            tag_d_reg <= tag_d_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= mag_next;
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            magz_reg <= mag_reg[2];
            num_reg  <= num_next;
            den_reg  <= den_next;
            data_reg <= data_next;
        end
    end

    assign out_tag  = tag_d_reg;
    assign out_data = data_reg;

endmodule

### hw/rtl/ppp_divider.sv
// pipelined restoring divider, one quotient bit per stage for both lanes
module ppp_divider
    import ppp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  ppp_tag_t  in_tag,
    input  div_data_t in_data,
    output ppp_tag_t  out_tag,
    output div_data_t out_data
);

    ppp_tag_t  tag_reg [Q_W];
    ppp_tag_t  tag_next [Q_W];
    div_data_t data_reg [Q_W];
    div_data_t data_next [Q_W];

    function automatic logic [ACC_W-1:0] div_step(logic [ACC_W-1:0] acc, logic [DEN_W-1:0] den);
        logic [ACC_W-1:0] sh;
        logic [REM_W:0]   diff;
        sh   = acc << 1;
        diff = {1'b0, sh[ACC_W-1:Q_W]} - (REM_W + 1)'(den);
        if (!diff[REM_W]) begin
            sh[ACC_W-1:Q_W] = diff[REM_W-1:0];
            sh[0]           = 1'b1;
        end
        return sh;
    endfunction

    always_comb begin
        for (int k = 0; k < Q_W; k++) begin
            if (k == 0) begin
                tag_next[k]        = in_tag;
                data_next[k].acc_x = div_step(in_data.acc_x, in_data.den);
                data_next[k].acc_y = div_step(in_data.acc_y, in_data.den);
                data_next[k].den   = in_data.den;
            end else begin
                tag_next[k]        = tag_reg[k-1];
                data_next[k].acc_x = div_step(data_reg[k-1].acc_x, data_reg[k-1].den);
                data_next[k].acc_y = div_step(data_reg[k-1].acc_y, data_reg[k-1].den);
                data_next[k].den   = data_reg[k-1].den;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < Q_W; k++) begin
                tag_reg[k] <= '0;
            end
        end else if (en) begin
            tag_reg <= tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_tag  = tag_reg[Q_W-1];
    assign out_data = data_reg[Q_W-1];

endmodule

### hw/rtl/ppp_output.sv
// principal point offset, saturation, frame test and output register
module ppp_output
    import ppp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  ppp_tag_t  in_tag,
    input  div_data_t in_data,
    input  cfg_t      cfg,
    output logic      out_valid,
    output pixel_t    out_data
);

    logic signed [RES_W-1:0]   rx, ry, cx, cy, col_raw, row_raw;
    logic signed [COORD_W-1:0] col_reg, col_next, row_reg, row_next;
    logic                      zero_reg, vld_reg, m_valid_reg;
    pixel_t                    m_data_reg, m_data_next;
    logic [SIZE_W-1:0]         img_w, img_h;

    function automatic logic signed [COORD_W-1:0] sat_coord(logic signed [RES_W-1:0] v);
        priority if (v > RES_W'(COORD_MAX)) begin
            return COORD_MAX;
        end else if (v < RES_W'(COORD_MIN)) begin
            return COORD_MIN;
        end else begin
            return COORD_W'(v);
        end
    endfunction

    always_comb begin
        rx = $signed(RES_W'(in_data.acc_x[Q_W-1:0]));
        ry = $signed(RES_W'(in_data.acc_y[Q_W-1:0]));
        if (in_tag.neg_x) begin
            rx = -rx;
        end
        if (in_tag.neg_y) begin
            ry = -ry;
        end
        cx      = $signed(RES_W'(cfg.principal_point[PP_W-1:0]));
        cy      = $signed(RES_W'(cfg.principal_point[2*PP_W-1:PP_W]));
        col_raw = cx - rx;
        row_raw = cy + ry;
    end

    always_comb begin
        priority if (in_tag.zero) begin
            col_next = '0;
        end else if (in_tag.ovf_x) begin
            col_next = in_tag.neg_x ? COORD_MAX : COORD_MIN;
        end else begin
            col_next = sat_coord(col_raw);
        end
        priority if (in_tag.zero) begin
            row_next = '0;
        end else if (in_tag.ovf_y) begin
            row_next = in_tag.neg_y ? COORD_MIN : COORD_MAX;
        end else begin
            row_next = sat_coord(row_raw);
        end
    end

    assign img_w = cfg.image_size[SIZE_W-1:0];
    assign img_h = cfg.image_size[2*SIZE_W-1:SIZE_W];

    always_comb begin
        m_data_next.col_pos    = col_reg;
        m_data_next.row_pos    = row_reg;
        m_data_next.depth_zero = zero_reg;
        m_data_next.in_frame   = !zero_reg
            && !col_reg[COORD_W-1] && ({1'b0, col_reg} < LIM_W'({img_w, FRAC_W'(0)}))
            && !row_reg[COORD_W-1] && ({1'b0, row_reg} < LIM_W'({img_h, FRAC_W'(0)}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= in_tag.valid;
            m_valid_reg <= vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            zero_reg   <= in_tag.zero;
            m_data_reg <= m_data_next;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;

endmodule

### hw/rtl/pinhole_point_projection.sv
// top level: configuration registers and the projection pipeline
// a point passes the transform, scale, divider and output stages in that order to reach the result
// throughput: one point per cycle while the result side does not stall, set by the one-bit-per-stage divider pipeline
// the whole pipeline holds while a result waits untaken; input is taken again once it moves
// aresetn (synchronous, active low) empties the pipeline and loads the register defaults
// configuration writes are taken in every cycle
module pinhole_point_projection
    import ppp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  point_t                s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pixel_t                m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg_reg, cfg_next;
    logic      en;
    logic      xf_valid;
    cam_t      xf_cam [3];
    ppp_tag_t  sc_tag, dv_tag;
    div_data_t sc_data, dv_data;

    assign cfg_ready = 1'b1;
    assign en        = m_ready || !m_valid;
    assign s_ready   = en;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROT_ROW0:        cfg_next.rot_row[0]      = cfg_data[ROT_ROW_W-1:0];
                REG_ROT_ROW1:        cfg_next.rot_row[1]      = cfg_data[ROT_ROW_W-1:0];
                REG_ROT_ROW2:        cfg_next.rot_row[2]      = cfg_data[ROT_ROW_W-1:0];
                REG_CAM_POS_XY:      cfg_next.cam_pos_xy      = cfg_data[CAM_XY_W-1:0];
                REG_CAM_POS_Z:       cfg_next.cam_pos_z       = cfg_data[CAM_Z_W-1:0];
                REG_FOCAL_PX:        cfg_next.focal_px        = cfg_data[FOCAL_W-1:0];
                REG_PRINCIPAL_POINT: cfg_next.principal_point = cfg_data[2*PP_W-1:0];
                REG_IMAGE_SIZE:      cfg_next.image_size      = cfg_data[2*SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rot_row[0]      <= ROT_ROW_W'(1) << (ROT_ROW_W - 2);
            cfg_reg.rot_row[1]      <= ROT_ROW_W'(1) << (ROT_ROW_W - 2 - ROT_W);
            cfg_reg.rot_row[2]      <= ROT_ROW_W'(1) << (ROT_ROW_W - 2 - 2 * ROT_W);
            cfg_reg.cam_pos_xy      <= '0;
            cfg_reg.cam_pos_z       <= '0;
            cfg_reg.focal_px        <= FOCAL_W'(256000);
            cfg_reg.principal_point <= '0;
            cfg_reg.image_size      <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ppp_transform u_transform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .cfg       (cfg_reg),
        .out_valid (xf_valid),
        .out_cam   (xf_cam)
    );

    ppp_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (xf_valid),
        .in_cam   (xf_cam),
        .cfg      (cfg_reg),
        .out_tag  (sc_tag),
        .out_data (sc_data)
    );

    ppp_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_tag   (sc_tag),
        .in_data  (sc_data),
        .out_tag  (dv_tag),
        .out_data (dv_data)
    );

    ppp_output u_output (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_tag    (dv_tag),
        .in_data   (dv_data),
        .cfg       (cfg_reg),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

endmodule

### hw/rtl/ppp_checker.sv
// port-level assertions for the projection block and their bind
module ppp_checker
    import ppp_pkg::*;
(
    input logic   aclk,
    input logic   aresetn,
    input logic   s_ready,
    input logic   m_valid,
    input logic   m_ready,
    input pixel_t m_data
);

    // zero depth gives a cleared result outside the frame
    a_zero_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.depth_zero |-> !m_data.in_frame && m_data.col_pos == '0
            && m_data.row_pos == '0)
        else $error("zero depth result not cleared");

    // an in-frame result has non-negative coordinates
    a_frame_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.in_frame |-> !m_data.col_pos[COORD_W-1] && !m_data.row_pos[COORD_W-1])
        else $error("in-frame result with negative coordinate");

    // input side never blocks while the result register is empty
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a stalled result transfer holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // reset leaves no valid result at the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind pinhole_point_projection ppp_checker u_ppp_checker (.*);
